// File: src/ptst_pkg.sv
// Shared types, codes and constants of the periodic timer slot table.
`default_nettype none

package ptst_pkg;

  // Default table depth
  localparam int unsigned NUM_SLOTS_DEF = 16;

  // Firings reported by one tick at most, and the width of their count
  localparam int unsigned MAX_FIRES = 16;
  localparam int unsigned FIRE_W    = 5;

  // Request codes
  localparam logic [1:0] REQ_TICK  = 2'd0;
  localparam logic [1:0] REQ_REG   = 2'd1;
  localparam logic [1:0] REQ_UNREG = 2'd2;

  // Result status codes
  localparam logic [2:0] ST_FIRED = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_REG   = 3'd2;
  localparam logic [2:0] ST_FULL  = 3'd3;
  localparam logic [2:0] ST_UNREG = 3'd4;

  // One request
  typedef struct packed {
    logic [1:0]  req_type;
    logic [3:0]  slot_index;
    logic [23:0] period_secs;
    logic [31:0] start_time;
    logic [15:0] user_tag;
  } in_item_t;

  // One result
  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  out_slot;
    logic [15:0] out_tag;
    logic [31:0] now_secs;
    logic        last_result;
  } out_item_t;

  // Contents of one slot in the slot memory
  typedef struct packed {
    logic [23:0] period;
    logic [31:0] due;
    logic [15:0] tag;
  } slot_data_t;

  // Write strobes of the slot memory
  typedef struct packed {
    logic we_due;
    logic we_all;
  } mem_wr_t;

  // Sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_TICK,
    S_TICK_END,
    S_REG
  } state_t;

endpackage

`default_nettype wire

// File: src/ptst_alu.sv
// Shared adder and due comparator of the timer slot table.
`default_nettype none

module ptst_alu (
  input  wire logic [31:0] op_a,
  input  wire logic [31:0] op_b,
  input  wire logic [31:0] op_c,
  output logic      [31:0] sum,
  output logic             le
);

  // Add modulo 2^32 and compare unsigned
  assign sum = op_a + op_b;
  assign le  = (op_a <= op_c);

endmodule

`default_nettype wire

// File: src/ptst_slot_mem.sv
// Slot memory: period, next due second and tag of every slot.
`default_nettype none

module ptst_slot_mem #(
  parameter int unsigned NUM_SLOTS = ptst_pkg::NUM_SLOTS_DEF,
  parameter int unsigned IDX_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1
) (
  input  wire logic                clk,
  input  wire ptst_pkg::mem_wr_t    wr,
  input  wire logic [IDX_W-1:0]    waddr,
  input  wire ptst_pkg::slot_data_t wdata,
  input  wire logic [IDX_W-1:0]    raddr,
  output ptst_pkg::slot_data_t      rdata
);

  logic [23:0] period_mem [NUM_SLOTS];
  logic [31:0] due_mem    [NUM_SLOTS];
  logic [15:0] tag_mem    [NUM_SLOTS];
  ptst_pkg::slot_data_t rdata_r;

  // Write one slot
  always_ff @(posedge clk) begin
    if (wr.we_all) begin
      period_mem[waddr] <= wdata.period;
      tag_mem[waddr]    <= wdata.tag;
    end
    if (wr.we_all || wr.we_due) begin
      due_mem[waddr] <= wdata.due;
    end
  end

  // Read one slot, registered
  always_ff @(posedge clk) begin
    rdata_r.period <= period_mem[raddr];
    rdata_r.due    <= due_mem[raddr];
    rdata_r.tag    <= tag_mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// File: src/ptst_ctrl.sv
// Sequencer of the timer slot table: request handling, slot scan and result register.
`default_nettype none

module ptst_ctrl #(
  parameter int unsigned NUM_SLOTS = ptst_pkg::NUM_SLOTS_DEF,
  parameter int unsigned IDX_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire ptst_pkg::in_item_t    in_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output ptst_pkg::out_item_t        out_data,
  output ptst_pkg::mem_wr_t          mem_wr,
  output logic      [IDX_W-1:0]     mem_waddr,
  output ptst_pkg::slot_data_t       mem_wdata,
  output logic      [IDX_W-1:0]     mem_raddr,
  input  wire ptst_pkg::slot_data_t  mem_rdata,
  output logic      [31:0]          alu_a,
  output logic      [31:0]          alu_b,
  output logic      [31:0]          alu_c,
  input  wire logic [31:0]          alu_sum,
  input  wire logic                 alu_le
);

  ptst_pkg::state_t    state_r, state_nxt;
  logic [IDX_W-1:0]    idx_r, idx_nxt;
  logic [31:0]         now_r, now_nxt;
  logic [NUM_SLOTS-1:0] active_r, active_nxt;
  logic [ptst_pkg::FIRE_W-1:0] fire_cnt_r, fire_cnt_nxt;
  logic                pend_valid_r, pend_valid_nxt;
  logic [3:0]          pend_slot_r, pend_slot_nxt;
  logic [15:0]         pend_tag_r, pend_tag_nxt;
  ptst_pkg::in_item_t  req_r, req_nxt;
  logic                out_valid_r, out_valid_nxt;
  ptst_pkg::out_item_t out_data_r, out_data_nxt;

  logic                in_acc;
  logic                can_emit;
  logic                last_idx;
  logic                hit;
  logic                cap;
  logic                stall;
  logic [IDX_W+3:0]    idx_ext;
  logic [IDX_W+3:0]    unreg_ext;
  logic                unreg_ok;

  // Handshake and scan conditions
  assign can_emit  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ptst_pkg::S_IDLE) && can_emit;
  assign in_acc    = in_valid && in_ready;
  assign last_idx  = (idx_r == IDX_W'(NUM_SLOTS - 1));
  assign hit       = active_r[idx_r] && alu_le;
  assign cap       = (fire_cnt_r == ptst_pkg::FIRE_W'(ptst_pkg::MAX_FIRES - 1));
  assign stall     = hit && pend_valid_r && !can_emit;
  assign idx_ext   = (IDX_W + 4)'(idx_r);
  assign unreg_ext = (IDX_W + 4)'(in_data.slot_index);
  assign unreg_ok  = (32'(in_data.slot_index) < NUM_SLOTS);

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign mem_waddr = idx_r;
  assign mem_raddr = idx_nxt;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ptst_pkg::S_IDLE: begin
        if (in_acc) begin
          if (in_data.req_type == ptst_pkg::REQ_TICK) begin
            state_nxt = ptst_pkg::S_TICK;
          end else if (in_data.req_type == ptst_pkg::REQ_REG) begin
            state_nxt = ptst_pkg::S_REG;
          end
        end
      end
      ptst_pkg::S_TICK: begin
        if (!stall && ((hit && cap) || last_idx)) begin
          state_nxt = ptst_pkg::S_TICK_END;
        end
      end
      ptst_pkg::S_TICK_END: begin
        if (can_emit) begin
          state_nxt = ptst_pkg::S_IDLE;
        end
      end
      ptst_pkg::S_REG: begin
        if (can_emit && (!active_r[idx_r] || last_idx)) begin
          state_nxt = ptst_pkg::S_IDLE;
        end
      end
      default: state_nxt = ptst_pkg::S_IDLE;
    endcase
  end

  // Datapath, memory and result control
  always_comb begin
    idx_nxt        = idx_r;
    now_nxt        = now_r;
    active_nxt     = active_r;
    fire_cnt_nxt   = fire_cnt_r;
    pend_valid_nxt = pend_valid_r;
    pend_slot_nxt  = pend_slot_r;
    pend_tag_nxt   = pend_tag_r;
    req_nxt        = req_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_data_nxt   = out_data_r;
    mem_wr         = '0;
    mem_wdata.period = req_r.period_secs;
    mem_wdata.due    = alu_sum;
    mem_wdata.tag    = req_r.user_tag;
    alu_a          = mem_rdata.due;
    alu_b          = {8'd0, mem_rdata.period};
    alu_c          = now_r;

    case (state_r)
      ptst_pkg::S_IDLE: begin
        if (in_acc) begin
          req_nxt        = in_data;
          idx_nxt        = '0;
          fire_cnt_nxt   = '0;
          pend_valid_nxt = 1'b0;
          // Free the slot and answer at once
          if (in_data.req_type == ptst_pkg::REQ_UNREG) begin
            if (unreg_ok) begin
              active_nxt[unreg_ext[IDX_W-1:0]] = 1'b0;
            end
            out_valid_nxt = 1'b1;
            out_data_nxt  = '{status: ptst_pkg::ST_UNREG, out_slot: in_data.slot_index,
                              out_tag: 16'd0, now_secs: now_r, last_result: 1'b1};
          end
        end
      end
      ptst_pkg::S_TICK: begin
        if (!stall) begin
          if (hit) begin
            // Send the previous firing, keep this one until the scan shows more
            if (pend_valid_r) begin
              out_valid_nxt = 1'b1;
              out_data_nxt  = '{status: ptst_pkg::ST_FIRED, out_slot: pend_slot_r,
                                out_tag: pend_tag_r, now_secs: now_r, last_result: 1'b0};
            end
            pend_valid_nxt = 1'b1;
            pend_slot_nxt  = idx_ext[3:0];
            pend_tag_nxt   = mem_rdata.tag;
            fire_cnt_nxt   = fire_cnt_r + 1'b1;
            mem_wr.we_due  = 1'b1;
          end
          if (!last_idx && !(hit && cap)) begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end
      ptst_pkg::S_TICK_END: begin
        // Close the tick with its final result, then advance the clock
        if (can_emit) begin
          out_valid_nxt = 1'b1;
          if (pend_valid_r) begin
            out_data_nxt = '{status: ptst_pkg::ST_FIRED, out_slot: pend_slot_r,
                             out_tag: pend_tag_r, now_secs: now_r, last_result: 1'b1};
          end else begin
            out_data_nxt = '{status: ptst_pkg::ST_IDLE, out_slot: 4'd0,
                             out_tag: 16'd0, now_secs: now_r, last_result: 1'b1};
          end
          pend_valid_nxt = 1'b0;
          now_nxt        = now_r + 32'd1;
        end
      end
      ptst_pkg::S_REG: begin
        alu_a = now_r;
        alu_b = {8'd0, req_r.period_secs};
        if (req_r.start_time != 32'd0) begin
          mem_wdata.due = req_r.start_time;
        end
        if (can_emit) begin
          if (!active_r[idx_r]) begin
            // Claim the lowest free slot
            mem_wr.we_all     = 1'b1;
            active_nxt[idx_r] = (req_r.period_secs != 24'd0);
            out_valid_nxt     = 1'b1;
            out_data_nxt      = '{status: ptst_pkg::ST_REG, out_slot: idx_ext[3:0],
                                  out_tag: 16'd0, now_secs: now_r, last_result: 1'b1};
          end else if (last_idx) begin
            out_valid_nxt = 1'b1;
            out_data_nxt  = '{status: ptst_pkg::ST_FULL, out_slot: 4'd0,
                              out_tag: 16'd0, now_secs: now_r, last_result: 1'b1};
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ptst_pkg::S_IDLE;
      idx_r        <= '0;
      now_r        <= '0;
      active_r     <= '0;
      fire_cnt_r   <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      idx_r        <= idx_nxt;
      now_r        <= now_nxt;
      active_r     <= active_nxt;
      fire_cnt_r   <= fire_cnt_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    pend_slot_r <= pend_slot_nxt;
    pend_tag_r  <= pend_tag_nxt;
    req_r       <= req_nxt;
    out_data_r  <= out_data_nxt;
  end

endmodule

`default_nettype wire

// File: src/periodic_timer_slot_table.sv
// Periodic timer slot table: top level.
// Unregister: result registered in the cycle after the request is accepted.
// Register: scans one slot per cycle from slot 0 while the result register can take a result.
// Tick: scans one slot per cycle via the slot memory read port unless a firing must wait;
// one result per firing up to MAX_FIRES, else an idle one. One request is in work at a time.
// Reset clears the seconds counter, the slot active bits and all control; the slot memory
// holds no reset value and needs no clearing pass.
`default_nettype none

module periodic_timer_slot_table #(
  parameter int unsigned NUM_SLOTS = ptst_pkg::NUM_SLOTS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire ptst_pkg::in_item_t in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output ptst_pkg::out_item_t     out_data
);

  localparam int unsigned IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  ptst_pkg::mem_wr_t    mem_wr;
  logic [IDX_W-1:0]     mem_waddr;
  logic [IDX_W-1:0]     mem_raddr;
  ptst_pkg::slot_data_t mem_wdata;
  ptst_pkg::slot_data_t mem_rdata;
  logic [31:0]          alu_a;
  logic [31:0]          alu_b;
  logic [31:0]          alu_c;
  logic [31:0]          alu_sum;
  logic                 alu_le;

  // Sequencer
  ptst_ctrl #(
    .NUM_SLOTS (NUM_SLOTS),
    .IDX_W     (IDX_W)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .mem_wr    (mem_wr),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata),
    .alu_a     (alu_a),
    .alu_b     (alu_b),
    .alu_c     (alu_c),
    .alu_sum   (alu_sum),
    .alu_le    (alu_le)
  );

  // Slot storage
  ptst_slot_mem #(
    .NUM_SLOTS (NUM_SLOTS),
    .IDX_W     (IDX_W)
  ) u_slot_mem (
    .clk   (clk),
    .wr    (mem_wr),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Shared add and compare unit
  ptst_alu u_alu (
    .op_a (alu_a),
    .op_b (alu_b),
    .op_c (alu_c),
    .sum  (alu_sum),
    .le   (alu_le)
  );

  // Unregister answers in the next cycle as a final result
  a_unreg_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_data.req_type == ptst_pkg::REQ_UNREG) |=>
      (out_valid && out_data.status == ptst_pkg::ST_UNREG && out_data.last_result))
    else $error("unregister request gave no unregister result");

  // A new request is taken only after the previous request's final result
  a_ready_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !(out_valid && !out_data.last_result))
    else $error("request accepted while a request still has results pending");

  // Only firings may be followed by more results of the same request
  a_nonfire_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status != ptst_pkg::ST_FIRED) |-> out_data.last_result)
    else $error("non-firing result not marked last");

endmodule

`default_nettype wire

// File: tb/sv/periodic_timer_slot_table_checker.sv
// Checker for the timer slot table: predicts each request's results and compares them.
`timescale 1ns / 100ps

module periodic_timer_slot_table_checker #(
  parameter int unsigned NUM_SLOTS = ptst_pkg::NUM_SLOTS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  input  wire logic                in_ready,
  input  wire ptst_pkg::in_item_t  in_data,
  input  wire logic                out_valid,
  input  wire logic                out_ready,
  input  wire ptst_pkg::out_item_t out_data,
  output int                       fail_count,
  output int                       pending_count,
  output int                       request_count,
  output int                       result_count,
  output int                       fire_count,
  output int                       full_count
);
  import ptst_pkg::*;

  // Shadow copy of the seconds counter and the slot table
  logic [31:0] secs_now;
  logic [23:0] slot_period [NUM_SLOTS];
  logic [31:0] slot_due    [NUM_SLOTS];
  logic [15:0] slot_tag    [NUM_SLOTS];

  // Results still owed by the table, oldest first
  out_item_t awaited_timer_results [$];

  int        errors;
  int        requests;
  int        results;
  int        fires;
  int        fulls;
  out_item_t want;

  // Append one result stamped with the current second
  task automatic owe_result(input logic [2:0] status, input logic [3:0] slot,
                            input logic [15:0] tag);
    out_item_t r;
    r             = '0;
    r.status      = status;
    r.out_slot    = slot;
    r.out_tag     = tag;
    r.now_secs    = secs_now;
    r.last_result = 1'b0;
    awaited_timer_results.push_back(r);
  endtask

  // Work out every result one request causes and advance the shadow state
  task automatic predict_timer_results(input in_item_t req);
    int          n;
    int          i;
    logic        placed;
    out_item_t   tail;
    n      = 0;
    placed = 1'b0;
    case (req.req_type)
      REQ_TICK: begin
        for (i = 0; i < NUM_SLOTS && n < MAX_FIRES; i++) begin
          if (slot_period[i] != '0 && slot_due[i] <= secs_now) begin
            owe_result(ST_FIRED, 4'(i), slot_tag[i]);
            slot_due[i] = slot_due[i] + 32'(slot_period[i]);
            n++;
            fires++;
          end
        end
        if (n == 0) begin
          owe_result(ST_IDLE, 4'd0, 16'd0);
          n = 1;
        end
        secs_now = secs_now + 32'd1;
      end
      REQ_REG: begin
        // claim the lowest free slot
        for (i = 0; i < NUM_SLOTS && !placed; i++) begin
          if (slot_period[i] == '0) begin
            slot_period[i] = req.period_secs;
            slot_tag[i]    = req.user_tag;
            slot_due[i]    = (req.start_time != '0) ? req.start_time
                                                    : secs_now + 32'(req.period_secs);
            owe_result(ST_REG, 4'(i), 16'd0);
            placed = 1'b1;
          end
        end
        if (!placed) begin
          owe_result(ST_FULL, 4'd0, 16'd0);
          fulls++;
        end
        n = 1;
      end
      REQ_UNREG: begin
        if (int'(req.slot_index) < NUM_SLOTS) slot_period[req.slot_index] = '0;
        owe_result(ST_UNREG, req.slot_index, 16'd0);
        n = 1;
      end
      default: begin
        // unknown request: drop it, no result
        n = 0;
      end
    endcase
    // mark the final result of this request
    if (n > 0) begin
      tail = awaited_timer_results.pop_back();
      tail.last_result = 1'b1;
      awaited_timer_results.push_back(tail);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      secs_now = '0;
      for (int s = 0; s < NUM_SLOTS; s++) begin
        slot_period[s] = '0;
        slot_due[s]    = '0;
        slot_tag[s]    = '0;
      end
      awaited_timer_results.delete();
    end else begin
      // take in a request first so its results queue behind older ones
      if (in_valid && in_ready) begin
        predict_timer_results(in_data);
        requests++;
      end
      // compare a delivered result against the oldest one owed
      if (out_valid && out_ready) begin
        results++;
        if (awaited_timer_results.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected result: status %0d slot %0d tag %h now %h last %b",
                     out_data.status, out_data.out_slot, out_data.out_tag,
                     out_data.now_secs, out_data.last_result);
        end else begin
          want = awaited_timer_results.pop_front();
          if (out_data.status !== want.status || out_data.out_slot !== want.out_slot ||
              out_data.out_tag !== want.out_tag || out_data.now_secs !== want.now_secs ||
              out_data.last_result !== want.last_result) begin
            errors++;
            if (errors <= 10)
              $display({"result %0d mismatch (expected/actual): status %0d/%0d ",
                        "slot %0d/%0d tag %h/%h now %h/%h last %b/%b"},
                       results, want.status, out_data.status, want.out_slot,
                       out_data.out_slot, want.out_tag, out_data.out_tag, want.now_secs,
                       out_data.now_secs, want.last_result, out_data.last_result);
          end
        end
      end
    end
    fail_count    <= errors;
    pending_count <= awaited_timer_results.size();
    request_count <= requests;
    result_count  <= results;
    fire_count    <= fires;
    full_count    <= fulls;
  end

endmodule

// File: tb/sv/periodic_timer_slot_table_tb.sv
// Testbench top for the timer slot table: clock, reset, request and result traffic, verdict.
`timescale 1ns / 100ps

module periodic_timer_slot_table_tb;
  import ptst_pkg::*;

  localparam int         ITEM_COUNT   = 460;
  localparam int         QUIET_TAIL   = 60;
  localparam int         LONG_HOLD    = 300;
  localparam int         DRAIN_CYCLES = 40;
  localparam int         CYCLE_LIMIT  = 400000;
  localparam logic [1:0] REQ_UNKNOWN  = 2'd3;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  int fail_count;
  int pending_count;
  int request_count;
  int result_count;
  int fire_count;
  int full_count;

  int cycle_count    = 0;
  int items_sent     = 0;
  int ticks_sent     = 0;
  bit quiet          = 1'b0;
  bit hold_go        = 1'b0;
  bit long_hold_done = 1'b0;

  periodic_timer_slot_table dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  periodic_timer_slot_table_checker checker_i (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_data      (out_data),
    .fail_count    (fail_count),
    .pending_count (pending_count),
    .request_count (request_count),
    .result_count  (result_count),
    .fire_count    (fire_count),
    .full_count    (full_count)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // End the run if it hangs
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending_count);
    $display("== FAIL ==");
    $finish;
  end

  // Random request of one kind; registers favor short periods and start times near now
  function automatic in_item_t random_request(input logic [1:0] kind);
    in_item_t    req;
    int unsigned pick;
    req.req_type    = kind;
    req.slot_index  = 4'($urandom_range(0, 15));
    req.period_secs = 24'($urandom());
    req.start_time  = $urandom();
    req.user_tag    = 16'($urandom());
    if (kind == REQ_REG) begin
      pick = $urandom_range(0, 19);
      if (pick == 0)      req.period_secs = '0;
      else if (pick == 1) req.period_secs = 24'hFF_FFFF;
      else if (pick > 3)  req.period_secs = 24'($urandom_range(1, 8));
      pick = $urandom_range(0, 9);
      if (pick < 5)       req.start_time = '0;
      else if (pick < 8)  req.start_time = 32'(ticks_sent + $urandom_range(0, 6));
      else if (pick == 8) req.start_time = 32'($urandom_range(1, ticks_sent + 1));
    end
    return req;
  endfunction

  // Offer one request, with an optional gap first, and hold it until accepted
  task automatic offer(input in_item_t req);
    if (!quiet && (items_sent / 40) % 2 == 0 && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_data  <= req;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (req.req_type == REQ_TICK) ticks_sent++;
    if (req.req_type != REQ_UNKNOWN) items_sent++;
  endtask

  // Result side: random stall bursts, one long hold-off once random traffic starts, then always ready
  initial begin
    wait (rst_n);
    forever begin
      if (quiet) begin
        out_ready <= 1'b1;
        @(posedge clk);
      end else if (hold_go && !long_hold_done) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        long_hold_done = 1'b1;
      end else if ($urandom_range(0, 2) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk);
      end
    end
  end

  initial begin
    in_item_t req;
    int       k;
    int       roll;
    int       burst;
    bit       paused;

    paused = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // tick on an empty table, unknown request, unregister of a free slot
    offer(random_request(REQ_TICK));
    offer(random_request(REQ_UNKNOWN));
    req = random_request(REQ_UNREG);
    req.slot_index = 4'd15;
    offer(req);

    // zero period: reported registered but slot 0 stays free
    req = random_request(REQ_REG);
    req.period_secs = '0;
    offer(req);

    // fill every slot; most are already due
    for (k = 0; k < NUM_SLOTS_DEF; k++) begin
      req = random_request(REQ_REG);
      req.period_secs = 24'(k + 1);
      req.start_time  = 32'd1;
      req.user_tag    = 16'(k * 4099);
      if (k == 0) begin
        req.period_secs = 24'hFF_FFFF;
        req.start_time  = 32'hFFFF_FFFF;
        req.user_tag    = 16'hFFFF;
      end else if (k == 1) begin
        req.start_time = '0;
      end else if (k == 2) begin
        req.user_tag = 16'h0000;
      end
      offer(req);
    end

    // table full, a tick with many firings, then free and reclaim slot 0
    offer(random_request(REQ_REG));
    offer(random_request(REQ_TICK));
    req = random_request(REQ_UNREG);
    req.slot_index = 4'd0;
    offer(req);
    offer(random_request(REQ_REG));

    // random traffic
    hold_go = 1'b1;
    while (items_sent < ITEM_COUNT) begin
      if (items_sent >= ITEM_COUNT - QUIET_TAIL) quiet = 1'b1;
      // hold the sender once until every result is in
      if (!paused && items_sent >= ITEM_COUNT / 2) begin
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0) @(posedge clk);
        paused = 1'b1;
      end
      roll = $urandom_range(0, 99);
      if (roll < 6) begin
        burst = $urandom_range(6, 17);
        repeat (burst) offer(random_request(REQ_REG));
      end else if (roll < 12) begin
        burst = $urandom_range(3, 10);
        repeat (burst) offer(random_request(REQ_TICK));
      end else if (roll < 52) begin
        offer(random_request(REQ_TICK));
      end else if (roll < 78) begin
        offer(random_request(REQ_REG));
      end else if (roll < 96) begin
        offer(random_request(REQ_UNREG));
      end else begin
        offer(random_request(REQ_UNKNOWN));
      end
    end

    // drain and let any stray result show up
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d requests (%0d ticks): %0d results, %0d firings, %0d full replies",
             request_count, ticks_sent, result_count, fire_count, full_count);
    if (fail_count == 0 && pending_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("mismatches: %0d, results outstanding: %0d", fail_count, pending_count);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
